// ===== rtl/dnms_pkg.sv =====
// dnms_pkg: types and constants shared by the distance NMS block.
// Word layouts for both channels, the retained-table entry and result codes.
// No dependencies.
`default_nettype none

package dnms_pkg;

  parameter int MAX_KEPT_DEF = 1024;

  parameter int LIMIT_W   = 34;
  parameter int MAG_W     = 23;
  parameter int SLOT_W    = 10;
  parameter int COUNT_W   = 11;
  parameter logic [LIMIT_W-1:0] LIMIT_RST = 34'd256;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_WEAKER  = 2'd2,
    ACT_FULL    = 2'd3
  } action_t;

  typedef struct packed {
    logic               first_of_list;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [23:0] strength;
  } in_word_t;

  typedef struct packed {
    action_t              action;
    logic [SLOT_W-1:0]    slot_index;
    logic [COUNT_W-1:0]   kept_count;
  } out_word_t;

  // one retained point; magnitude is already the saturated absolute strength
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [MAG_W-1:0]   mag;
  } entry_t;

  parameter int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/dnms_if.sv =====
// dnms_if: valid/ready channel interfaces for the point input and result output.
// Depends on dnms_pkg for the word types.
`default_nettype none

interface dnms_in_if;
  logic               valid;
  logic               ready;
  dnms_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dnms_out_if;
  logic                valid;
  logic                ready;
  dnms_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dnms_ram.sv =====
// dnms_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none

module dnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/dnms_dist_lane.sv =====
// dnms_dist_lane: row of pipeline cells that test one table entry per cycle
// against the current point (difference, square, sum and compare).
// Depends on dnms_pkg; fed from dnms_ram read data.
`default_nettype none

module dnms_dist_lane #(
  parameter int AW = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          flush,
  input  wire logic                          issue_valid,
  input  wire logic [AW-1:0]                 issue_slot,
  input  wire dnms_pkg::entry_t              entry,
  input  wire logic signed [15:0]            px,
  input  wire logic signed [15:0]            py,
  input  wire logic [dnms_pkg::LIMIT_W-1:0]  limit,
  output logic                               hit_valid,
  output logic [AW-1:0]                      hit_slot,
  output logic [dnms_pkg::MAG_W-1:0]         hit_mag,
  output logic                               busy
);

  // cell 0: tag alongside the registered RAM read
  logic          v0_r;
  logic [AW-1:0] slot0_r;
  // cell 1: absolute differences
  logic                       v1_r;
  logic [AW-1:0]              slot1_r;
  logic [dnms_pkg::MAG_W-1:0] mag1_r;
  logic [15:0]                adx1_r, ady1_r;
  // cell 2: squares
  logic                       v2_r;
  logic [AW-1:0]              slot2_r;
  logic [dnms_pkg::MAG_W-1:0] mag2_r;
  logic [31:0]                sqx2_r, sqy2_r;
  // cell 3: compare result
  logic                       hv3_r;
  logic [AW-1:0]              slot3_r;
  logic [dnms_pkg::MAG_W-1:0] mag3_r;

  logic [16:0] dx, dy, adx, ady;
  logic [32:0] sum_sq;
  logic        near;

  always_comb begin
    dx     = {px[15], px} - {entry.x[15], entry.x};
    dy     = {py[15], py} - {entry.y[15], entry.y};
    adx    = dx[16] ? (~dx + 17'd1) : dx;
    ady    = dy[16] ? (~dy + 17'd1) : dy;
    sum_sq = {1'b0, sqx2_r} + {1'b0, sqy2_r};
    near   = {1'b0, sum_sq} < limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      hv3_r <= 1'b0;
    end else begin
      v0_r  <= issue_valid;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      hv3_r <= v2_r && near;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= issue_slot;
    slot1_r <= slot0_r;
    mag1_r  <= entry.mag;
    adx1_r  <= adx[15:0];
    ady1_r  <= ady[15:0];
    slot2_r <= slot1_r;
    mag2_r  <= mag1_r;
    sqx2_r  <= adx1_r * adx1_r;
    sqy2_r  <= ady1_r * ady1_r;
    slot3_r <= slot2_r;
    mag3_r  <= mag2_r;
  end

  assign hit_valid = hv3_r;
  assign hit_slot  = slot3_r;
  assign hit_mag   = mag3_r;
  assign busy      = v0_r | v1_r | v2_r | hv3_r;

endmodule

`default_nettype wire

// ===== rtl/distance_non_max_suppression_core.sv =====
// distance_non_max_suppression_core: greedy radius NMS over a point stream.
// Depends on dnms_pkg, dnms_if, dnms_ram and dnms_dist_lane.
//
//   port       dir   handshake            word
//   in_ch      sink  valid/ready          first_of_list, point_x, point_y, strength
//   out_ch     src   valid/ready          action, slot_index, kept_count
//   cfg_*      in    cfg_we, no ready     dist_sq_limit (34 bit)
//
// One point at a time. The search walks the retained entries newest first up to
// and including the first near one, at most the kept count; with an empty table
// nothing is walked. The table RAM has one read port, one entry a cycle.
// Synchronous active-low reset clears the count and sets the limit to 256;
// the table itself is not cleared. A result waiting on out_ch does not block
// the next point's search; only its resolve cycle waits for the output slot.
`default_nettype none

module distance_non_max_suppression_core #(
  parameter int MAX_KEPT = dnms_pkg::MAX_KEPT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  dnms_in_if.sink                           in_ch,
  dnms_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [dnms_pkg::LIMIT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_KEPT);
  localparam int CW = $clog2(MAX_KEPT + 1);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_SEARCH  = 3'b010,
    S_RESOLVE = 3'b100
  } state_t;

  function automatic logic [dnms_pkg::MAG_W-1:0] sat_abs(input logic [23:0] s);
    logic [23:0] a;
    a = s[23] ? (~s + 24'd1) : s;
    if (s == 24'h800000) begin
      return {dnms_pkg::MAG_W{1'b1}};
    end
    return a[dnms_pkg::MAG_W-1:0];
  endfunction

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                issue_cnt_r, issue_cnt_nxt;
  logic [dnms_pkg::LIMIT_W-1:0] limit_r;
  logic signed [15:0]           px_r, py_r;
  logic [dnms_pkg::MAG_W-1:0]   mag_r;
  logic                         found_r, found_nxt;
  logic [AW-1:0]                fslot_r, fslot_nxt;
  logic [dnms_pkg::MAG_W-1:0]   fmag_r, fmag_nxt;
  logic                         out_valid_r, out_valid_nxt;
  dnms_pkg::out_word_t          out_word_r, out_word_nxt;

  logic                         in_fire, resolve_go, lane_flush;
  logic                         issue_valid;
  logic [CW-1:0]                issue_dec;
  logic [AW-1:0]                raddr;
  logic                         ram_we;
  logic [AW-1:0]                waddr;
  dnms_pkg::entry_t             wentry, rentry;
  logic [dnms_pkg::ENTRY_W-1:0] ram_rdata;
  logic                         lane_hit, lane_busy;
  logic [AW-1:0]                lane_slot;
  logic [dnms_pkg::MAG_W-1:0]   lane_mag;
  logic [AW-1:0]                res_slot;
  logic [AW+dnms_pkg::SLOT_W-1:0]  slot_ext;
  logic [CW+dnms_pkg::COUNT_W-1:0] count_ext;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign resolve_go   = (state_r == S_RESOLVE) && (!out_valid_r || out_ch.ready);
  assign issue_dec    = issue_cnt_r - CW'(1);
  assign raddr        = issue_dec[AW-1:0];
  assign issue_valid  = (state_r == S_SEARCH) && (issue_cnt_r != '0) && !lane_hit;
  assign lane_flush   = (state_r == S_SEARCH) && lane_hit;
  assign rentry       = ram_rdata;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_cnt_nxt = issue_cnt_r;
    found_nxt     = found_r;
    fslot_nxt     = fslot_r;
    fmag_nxt      = fmag_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    waddr         = fslot_r;
    res_slot      = '0;
    slot_ext      = '0;
    count_ext     = '0;
    wentry.x      = px_r;
    wentry.y      = py_r;
    wentry.mag    = mag_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.first_of_list) begin
            count_nxt     = '0;
            issue_cnt_nxt = '0;
          end else begin
            issue_cnt_nxt = count_r;
          end
          found_nxt = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lane_hit) begin
          found_nxt = 1'b1;
          fslot_nxt = lane_slot;
          fmag_nxt  = lane_mag;
          state_nxt = S_RESOLVE;
        end else if (issue_cnt_r == '0 && !lane_busy) begin
          state_nxt = S_RESOLVE;
        end else if (issue_cnt_r != '0) begin
          issue_cnt_nxt = issue_dec;
        end
      end
      S_RESOLVE: begin
        if (resolve_go) begin
          if (found_r) begin
            res_slot = fslot_r;
            if (mag_r > fmag_r) begin
              ram_we              = 1'b1;
              out_word_nxt.action = dnms_pkg::ACT_REPLACE;
            end else begin
              out_word_nxt.action = dnms_pkg::ACT_WEAKER;
            end
          end else if (count_r == CW'(MAX_KEPT)) begin
            out_word_nxt.action = dnms_pkg::ACT_FULL;
          end else begin
            res_slot            = count_r[AW-1:0];
            waddr               = count_r[AW-1:0];
            ram_we              = 1'b1;
            count_nxt           = count_r + CW'(1);
            out_word_nxt.action = dnms_pkg::ACT_APPEND;
          end
          slot_ext                 = {{dnms_pkg::SLOT_W{1'b0}}, res_slot};
          count_ext                = {{dnms_pkg::COUNT_W{1'b0}}, count_nxt};
          out_word_nxt.slot_index  = slot_ext[dnms_pkg::SLOT_W-1:0];
          out_word_nxt.kept_count  = count_ext[dnms_pkg::COUNT_W-1:0];
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resolve_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_cnt_r <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= dnms_pkg::LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    fslot_r    <= fslot_nxt;
    fmag_r     <= fmag_nxt;
    out_word_r <= out_word_nxt;
    if (in_fire) begin
      px_r  <= in_ch.data.point_x;
      py_r  <= in_ch.data.point_y;
      mag_r <= sat_abs(in_ch.data.strength);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  dnms_ram #(
    .WIDTH (dnms_pkg::ENTRY_W),
    .DEPTH (MAX_KEPT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  dnms_dist_lane #(
    .AW (AW)
  ) u_lane (
    .clk         (clk),
    .rst_n       (rst_n),
    .flush       (lane_flush),
    .issue_valid (issue_valid),
    .issue_slot  (raddr),
    .entry       (rentry),
    .px          (px_r),
    .py          (py_r),
    .limit       (limit_r),
    .hit_valid   (lane_hit),
    .hit_slot    (lane_slot),
    .hit_mag     (lane_mag),
    .busy        (lane_busy)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_KEPT))
    else $error("kept count beyond table depth");

  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_RESOLVE) && !lane_busy)
    else $error("table write while a search is in flight");

  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SEARCH) && !lane_busy)
    else $error("accepted word did not start a clean search");

  a_out_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESOLVE))
    else $error("result raised outside resolve");
`endif

endmodule

`default_nettype wire
